>>> hdl/sobel_edge_overlay_filter_macros.svh
// ----------------------------------------------------------------------------
// Sobel edge overlay filter: assertion macros
// Shared concurrent assertion forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef SOBEL_EDGE_OVERLAY_FILTER_MACROS_SVH
`define SOBEL_EDGE_OVERLAY_FILTER_MACROS_SVH

// same-cycle implication, held off during reset
`define SEOF_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define SEOF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/seof_pkg.sv
// ----------------------------------------------------------------------------
// seof_pkg
// Constants, register codes and shared types of the Sobel edge overlay filter.
// ----------------------------------------------------------------------------
`default_nettype none

package seof_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int COL_W = $clog2(MAX_WIDTH);       // column index
  localparam int W_W   = $clog2(MAX_WIDTH + 1);   // row length, up to MAX_WIDTH
  localparam int H_W   = $clog2(MAX_HEIGHT + 2);  // row counter, up to height + 1

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_MODE  = 2'd2;
  localparam logic [CFG_DATA_W-1:0] LINE_WIDTH_RST   = 11'd1024;
  localparam logic [CFG_DATA_W-1:0] FRAME_HEIGHT_RST = 11'd1024;

  // luma in fixed point
  localparam int LUMA_KR    = 306;
  localparam int LUMA_KG    = 600;
  localparam int LUMA_KB    = 117;
  localparam int LUMA_SHIFT = 10;
  localparam int LSUM_W     = 18;

  // Sobel sums and magnitude
  localparam int S_W = 10;   // one weighted column or row, max 4*255
  localparam int G_W = 11;   // |gx| + |gy|

  // edge mapping: (g-100)*255/700 == (g-100)*51/140
  localparam int EDGE_LOW    = 100;
  localparam int EDGE_HIGH   = 800;
  localparam int EDGE_SPAN   = 700;
  localparam int FULL        = 255;
  localparam int X_W         = 10;
  localparam int T_W         = 16;
  localparam int SPAN_RED    = EDGE_SPAN / 5;
  localparam int SCALE_RED   = FULL / 5;
  localparam int RECIP_SHIFT = 20;
  localparam int RECIP       = (1 << RECIP_SHIFT) / SPAN_RED;
  localparam int Q_PROD_W    = RECIP_SHIFT + 8;

  // dimming by three through a reciprocal, exact for 8-bit inputs
  localparam int DIM_DIV    = 3;
  localparam int DIM_SHIFT  = 9;
  localparam int DIM_RECIP  = (1 << DIM_SHIFT) / DIM_DIV + 1;
  localparam int D_PROD_W   = 8 + DIM_SHIFT;

  // overlay product (v - d) * v, signed
  localparam int P_W = 18;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pix_t;

  // one line memory entry: luma one and two rows up, RGBA of the row above
  typedef struct packed {
    logic [7:0] luma_a;
    logic [7:0] luma_b;
    pix_t       pix;
  } mem_entry_t;

  // window stage to edge mapping stage
  typedef struct packed {
    logic           emit;
    logic           last;
    logic [G_W-1:0] g;
    pix_t           pix;
  } seof_hand_t;

endpackage

`default_nettype wire

>>> hdl/seof_in_if.sv
// ----------------------------------------------------------------------------
// seof_in_if
// Pixel input channel: valid/ready handshake with RGBA payload and drain flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface seof_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;
  logic [7:0] in_alpha;
  logic       drain;

  modport source (output valid, in_red, in_green, in_blue, in_alpha, drain,
                  input ready);
  modport sink   (input valid, in_red, in_green, in_blue, in_alpha, drain,
                  output ready);
endinterface

`default_nettype wire

>>> hdl/seof_out_if.sv
// ----------------------------------------------------------------------------
// seof_out_if
// Filtered pixel output channel: valid/ready handshake with RGBA and frame end.
// ----------------------------------------------------------------------------
`default_nettype none

interface seof_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [7:0] out_alpha;
  logic       frame_last;

  modport source (output valid, out_red, out_green, out_blue, out_alpha, frame_last,
                  input ready);
  modport sink   (input valid, out_red, out_green, out_blue, out_alpha, frame_last,
                  output ready);
endinterface

`default_nettype wire

>>> hdl/seof_window.sv
// ----------------------------------------------------------------------------
// seof_window
// Stream position, line memory read-modify-write, 3x3 window and Sobel sum.
// ----------------------------------------------------------------------------
`default_nettype none

module seof_window import seof_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  pix_t           pix_in,
  input  logic           drain_in,
  input  logic [W_W-1:0] width,
  input  logic [H_W-1:0] height,
  output logic           idle,
  output logic           hand_valid,
  output seof_hand_t     hand
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_LUMA  = 2'd1;
  localparam logic [1:0] ST_SOBEL = 2'd2;

  logic [1:0] state_r, state_nxt;

  mem_entry_t mem [MAX_WIDTH];
  mem_entry_t rd_r;

  logic [COL_W-1:0] col_r, col_nxt;
  logic [H_W-1:0]   row_r, row_nxt;
  logic [COL_W-1:0] col_e;
  logic [H_W-1:0]   row_e;
  logic [H_W-1:0]   h_plus1;
  logic [W_W-1:0]   col_inc;
  logic             restart, is_pix;

  // stage A: item registers
  logic [COL_W-1:0] a_col_r;
  logic [H_W-1:0]   a_row_r;
  pix_t             a_pix_r;

  // stage B: luma and border flags
  logic [LSUM_W-1:0] luma_sum;
  logic              col_pos;
  logic [W_W-1:0]    xc;
  logic [H_W-1:0]    yc;
  logic [7:0]        b_luma_r;
  logic              b_emit_r, b_last_r, b_lok_r, b_rok_r, b_r0ok_r, b_r2ok_r;

  // stage C: Sobel
  logic [7:0]     win_r [6];
  logic [7:0]     colr [3];
  logic [7:0]     z [3][3];
  logic           rowok [3];
  logic [S_W-1:0] s_left, s_right, s_top, s_bot;
  logic [S_W-1:0] ax, ay;
  pix_t           held_r;

  assign h_plus1 = height + H_W'(1);

  // position of this item, restarted when it falls outside the frame
  always_comb begin
    restart = (W_W'(col_r) >= width) || (row_r > h_plus1) ||
              ((row_r == h_plus1) && (col_r != '0));
    col_e   = restart ? '0 : col_r;
    row_e   = restart ? '0 : row_r;
    is_pix  = (row_e < height) && !drain_in;
    col_inc = W_W'(col_e) + W_W'(1);
    if (row_e == h_plus1) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (col_inc >= width) begin
      col_nxt = '0;
      row_nxt = row_e + H_W'(1);
    end else begin
      col_nxt = col_inc[COL_W-1:0];
      row_nxt = row_e;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (start) state_nxt = ST_LUMA;
      ST_LUMA:  state_nxt = ST_SOBEL;
      ST_SOBEL: state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      col_r   <= '0;
      row_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (start) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_col_r <= col_e;
      a_row_r <= row_e;
      a_pix_r <= is_pix ? pix_in : '0;
    end
  end

  // line memory: read on accept, written back in the Sobel step
  always_ff @(posedge clk) begin
    if (start) rd_r <= mem[col_e];
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_SOBEL) begin
      mem[a_col_r] <= '{luma_a: b_luma_r, luma_b: rd_r.luma_a, pix: a_pix_r};
    end
  end

  // stage B
  always_comb begin
    luma_sum = LSUM_W'(LUMA_KR * a_pix_r.red) + LSUM_W'(LUMA_KG * a_pix_r.green) +
               LSUM_W'(LUMA_KB * a_pix_r.blue);
    col_pos  = (a_col_r != '0);
    xc       = col_pos ? (W_W'(a_col_r) - W_W'(1)) : (width - W_W'(1));
    yc       = a_row_r - (col_pos ? H_W'(1) : H_W'(2));
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_LUMA) begin
      b_luma_r <= luma_sum[LSUM_W-1:LUMA_SHIFT];
      b_emit_r <= (a_row_r >= H_W'(2)) || ((a_row_r == H_W'(1)) && col_pos);
      b_last_r <= (a_row_r == h_plus1);
      b_lok_r  <= (xc != '0);
      b_rok_r  <= ((xc + W_W'(1)) < width);
      b_r0ok_r <= (yc != '0);
      b_r2ok_r <= ((yc + H_W'(1)) < height);
    end
  end

  // stage C: window taps with out-of-frame neighbors forced to zero
  always_comb begin
    colr[0]  = rd_r.luma_b;
    colr[1]  = rd_r.luma_a;
    colr[2]  = b_luma_r;
    rowok[0] = b_r0ok_r;
    rowok[1] = 1'b1;
    rowok[2] = b_r2ok_r;
    for (int i = 0; i < 3; i++) begin
      z[i][0] = (b_lok_r && rowok[i]) ? win_r[i] : 8'd0;
      z[i][1] = rowok[i] ? win_r[3+i] : 8'd0;
      z[i][2] = (b_rok_r && rowok[i]) ? colr[i] : 8'd0;
    end
    s_left  = S_W'(z[0][0]) + {1'b0, z[1][0], 1'b0} + S_W'(z[2][0]);
    s_right = S_W'(z[0][2]) + {1'b0, z[1][2], 1'b0} + S_W'(z[2][2]);
    s_bot   = S_W'(z[2][0]) + {1'b0, z[2][1], 1'b0} + S_W'(z[2][2]);
    s_top   = S_W'(z[0][0]) + {1'b0, z[0][1], 1'b0} + S_W'(z[0][2]);
    ax      = (s_left >= s_right) ? (s_left - s_right) : (s_right - s_left);
    ay      = (s_bot >= s_top) ? (s_bot - s_top) : (s_top - s_bot);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) win_r[i] <= '0;
      held_r <= '0;
    end else if (state_r == ST_SOBEL) begin
      win_r[0] <= win_r[3];
      win_r[1] <= win_r[4];
      win_r[2] <= win_r[5];
      win_r[3] <= colr[0];
      win_r[4] <= colr[1];
      win_r[5] <= colr[2];
      held_r   <= rd_r.pix;
    end
  end

  assign idle       = (state_r == ST_IDLE);
  assign hand_valid = (state_r == ST_SOBEL);
  assign hand.emit  = b_emit_r;
  assign hand.last  = b_last_r;
  assign hand.g     = G_W'(ax) + G_W'(ay);
  assign hand.pix   = held_r;

endmodule

`default_nettype wire

>>> hdl/seof_edge_map.sv
// ----------------------------------------------------------------------------
// seof_edge_map
// Maps edge magnitude to gray level, applies overlay, holds the output beat.
// ----------------------------------------------------------------------------
`default_nettype none

module seof_edge_map import seof_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       hand_valid,
  input  seof_hand_t hand,
  input  logic       mode,
  output logic       busy,
  output logic       out_valid,
  input  logic       out_ready,
  output pix_t       out_pix,
  output logic       out_last
);

  // S1: offset, scale, dim
  logic [X_W-1:0]      x;
  logic [D_PROD_W-1:0] dprod [3];
  logic [7:0]          chan_in [3];
  logic                s1_v_r, s1_lo_r, s1_hi_r, s1_last_r;
  logic [T_W-1:0]      s1_t_r;
  logic [7:0]          s1_d_r [3];
  pix_t                s1_pix_r;

  // S2: reciprocal estimate
  logic [Q_PROD_W-1:0] qprod;
  logic                s2_v_r, s2_lo_r, s2_hi_r, s2_last_r;
  logic [T_W-1:0]      s2_t_r;
  logic [7:0]          s2_q0_r;
  logic [7:0]          s2_d_r [3];
  pix_t                s2_pix_r;

  // S3: correction
  logic [T_W-1:0] rem;
  logic [7:0]     v;
  logic           s3_v_r, s3_last_r;
  logic [7:0]     s3_v8_r;
  logic [7:0]     s3_d_r [3];
  pix_t           s3_pix_r;

  // S4: overlay product
  logic signed [9:0]  diff [3];
  logic signed [19:0] prod [3];
  logic               s4_v_r, s4_last_r;
  logic [7:0]         s4_v8_r;
  logic [P_W-1:0]     s4_p_r [3];
  logic [7:0]         s4_d_r [3];
  pix_t               s4_pix_r;

  // output
  logic [P_W-1:0] mag [3];
  logic [15:0]    qsum [3];
  logic [7:0]     ch [3];
  logic           load;
  logic           out_valid_r, out_last_r;
  pix_t           out_pix_r;

  assign chan_in[0] = hand.pix.red;
  assign chan_in[1] = hand.pix.green;
  assign chan_in[2] = hand.pix.blue;

  always_comb begin
    x = X_W'(hand.g - G_W'(EDGE_LOW));
    for (int i = 0; i < 3; i++) dprod[i] = D_PROD_W'(chan_in[i] * DIM_RECIP);
  end

  always_ff @(posedge clk) begin
    if (hand_valid) begin
      s1_t_r    <= T_W'(x * SCALE_RED);
      s1_lo_r   <= (hand.g < G_W'(EDGE_LOW));
      s1_hi_r   <= (hand.g >= G_W'(EDGE_HIGH));
      s1_last_r <= hand.last;
      s1_pix_r  <= hand.pix;
      for (int i = 0; i < 3; i++) s1_d_r[i] <= dprod[i][D_PROD_W-1:DIM_SHIFT];
    end
  end

  assign qprod = Q_PROD_W'(s1_t_r * RECIP);

  always_ff @(posedge clk) begin
    s2_t_r    <= s1_t_r;
    s2_q0_r   <= qprod[Q_PROD_W-1:RECIP_SHIFT];
    s2_lo_r   <= s1_lo_r;
    s2_hi_r   <= s1_hi_r;
    s2_last_r <= s1_last_r;
    s2_pix_r  <= s1_pix_r;
    s2_d_r    <= s1_d_r;
  end

  // the estimate is low by at most one
  always_comb begin
    rem = s2_t_r - T_W'(s2_q0_r * SPAN_RED);
    if (s2_lo_r)                       v = 8'd0;
    else if (s2_hi_r)                  v = 8'(FULL);
    else if (rem >= T_W'(SPAN_RED))    v = s2_q0_r + 8'd1;
    else                               v = s2_q0_r;
  end

  always_ff @(posedge clk) begin
    s3_v8_r   <= v;
    s3_last_r <= s2_last_r;
    s3_pix_r  <= s2_pix_r;
    s3_d_r    <= s2_d_r;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i] = $signed({2'b00, s3_v8_r}) - $signed({2'b00, s3_d_r[i]});
      prod[i] = diff[i] * $signed({2'b00, s3_v8_r});
    end
  end

  always_ff @(posedge clk) begin
    if (s3_v_r) begin
      s4_v8_r   <= s3_v8_r;
      s4_last_r <= s3_last_r;
      s4_pix_r  <= s3_pix_r;
      s4_d_r    <= s3_d_r;
      for (int i = 0; i < 3; i++) s4_p_r[i] <= prod[i][P_W-1:0];
    end
  end

  // divide by 255 with truncation toward zero, on the magnitude
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i]  = s4_p_r[i][P_W-1] ? (~s4_p_r[i] + P_W'(1)) : s4_p_r[i];
      qsum[i] = mag[i][15:0] + 16'(mag[i][15:8]) + 16'd1;
      ch[i]   = s4_p_r[i][P_W-1] ? (s4_d_r[i] - qsum[i][15:8])
                                 : (s4_d_r[i] + qsum[i][15:8]);
    end
  end

  assign load = s4_v_r && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      s4_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_v_r <= hand_valid && hand.emit;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      if (s3_v_r)    s4_v_r <= 1'b1;
      else if (load) s4_v_r <= 1'b0;
      if (load)           out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_last_r <= s4_last_r;
      if (mode) begin
        out_pix_r.red   <= ch[0];
        out_pix_r.green <= ch[1];
        out_pix_r.blue  <= ch[2];
        out_pix_r.alpha <= s4_pix_r.alpha;
      end else begin
        out_pix_r.red   <= s4_v8_r;
        out_pix_r.green <= s4_v8_r;
        out_pix_r.blue  <= s4_v8_r;
        out_pix_r.alpha <= 8'd0;
      end
    end
  end

  assign busy      = s1_v_r || s2_v_r || s3_v_r || s4_v_r;
  assign out_valid = out_valid_r;
  assign out_pix   = out_pix_r;
  assign out_last  = out_last_r;

endmodule

`default_nettype wire

>>> hdl/sobel_edge_overlay_filter.sv
// ----------------------------------------------------------------------------
// sobel_edge_overlay_filter
// 3x3 Sobel edge filter on a raster RGBA stream with optional edge overlay.
// ----------------------------------------------------------------------------
// Pixels enter in raster order, one per in_ch beat; each becomes 8-bit luma
// ((306r + 600g + 117b) >> 10) and lands in a 1024-entry line memory that
// holds, per column, the luma of the two rows above and the RGBA of the row
// above. Sobel magnitude g = |gx| + |gy| (neighbors outside the frame count
// as zero) maps to v: 0 below 100, (g-100)*255/700 below 800, else 255.
// output_mode 0 sends gray (v,v,v) with alpha 0; mode 1 sends each channel
// as c/3 + (v - c/3)*v/255 with alpha kept. The result for a pixel leaves
// line_width+1 beats after that pixel entered, so a frame needs
// W*H + W + 1 beats: after the last pixel, send W+1 beats with drain set
// (any beat past the frame end acts as a drain). frame_last marks the final
// result; the position counters then wrap to the frame start. Width and
// height of 0 act as 1, above 1024 they saturate. Configure only while idle;
// changing geometry mid-frame restarts the frame if the position falls
// outside it. No clearing pass: the memory needs no init after reset.
// Throughput: one item in flight at a time. A beat that yields a result
// holds in_ch.ready low through memory read, luma, Sobel and write-back, then
// edge mapping/overlay stages S1-S4 until it loads the output register; others
// release it after write-back. The output register decouples the sides: a new
// beat is taken while a result waits, but no result loads until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module sobel_edge_overlay_filter import seof_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  seof_in_if.sink               in_ch,
  seof_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // config registers
  logic [CFG_DATA_W-1:0] line_width_r;
  logic [CFG_DATA_W-1:0] frame_height_r;
  logic                  output_mode_r;

  // clamped geometry
  logic [W_W-1:0] width_c;
  logic [H_W-1:0] height_c;

  logic       in_ready, start;
  logic       win_idle, edge_busy;
  logic       hand_valid;
  seof_hand_t hand;
  pix_t       pix_in;
  pix_t       out_pix;
  logic       out_valid, out_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r   <= LINE_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
      output_mode_r  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LINE_WIDTH:   line_width_r   <= cfg_data;
        REG_FRAME_HEIGHT: frame_height_r <= cfg_data;
        REG_OUTPUT_MODE:  output_mode_r  <= cfg_data[0];
        default: ;  // unmapped index, ignored
      endcase
    end
  end

  always_comb begin
    if (line_width_r == '0)                          width_c = W_W'(1);
    else if (line_width_r > CFG_DATA_W'(MAX_WIDTH))  width_c = W_W'(MAX_WIDTH);
    else                                             width_c = W_W'(line_width_r);
    if (frame_height_r == '0)                        height_c = H_W'(1);
    else if (frame_height_r > CFG_DATA_W'(MAX_HEIGHT)) height_c = H_W'(MAX_HEIGHT);
    else                                             height_c = H_W'(frame_height_r);
  end

  // one item at a time: take a beat only once the previous one is through
  assign in_ready    = win_idle && !edge_busy;
  assign in_ch.ready = in_ready;
  assign start       = in_ch.valid && in_ready;

  assign pix_in.red   = in_ch.in_red;
  assign pix_in.green = in_ch.in_green;
  assign pix_in.blue  = in_ch.in_blue;
  assign pix_in.alpha = in_ch.in_alpha;

  seof_window u_window (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .pix_in     (pix_in),
    .drain_in   (in_ch.drain),
    .width      (width_c),
    .height     (height_c),
    .idle       (win_idle),
    .hand_valid (hand_valid),
    .hand       (hand)
  );

  seof_edge_map u_edge_map (
    .clk        (clk),
    .rst_n      (rst_n),
    .hand_valid (hand_valid),
    .hand       (hand),
    .mode       (output_mode_r),
    .busy       (edge_busy),
    .out_valid  (out_valid),
    .out_ready  (out_ch.ready),
    .out_pix    (out_pix),
    .out_last   (out_last)
  );

  assign out_ch.valid      = out_valid;
  assign out_ch.out_red    = out_pix.red;
  assign out_ch.out_green  = out_pix.green;
  assign out_ch.out_blue   = out_pix.blue;
  assign out_ch.out_alpha  = out_pix.alpha;
  assign out_ch.frame_last = out_last;

endmodule

`default_nettype wire

>>> hdl/seof_chk.sv
// ----------------------------------------------------------------------------
// seof_chk
// Port-level checker for the Sobel edge overlay filter, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sobel_edge_overlay_filter_macros.svh"

module seof_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [32:0] out_payload
);

  // a stalled result beat keeps its data
  `SEOF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_payload), "output beat changed while stalled")

  // an accepted beat occupies the block for at least the following cycle
  `SEOF_ASSERT_NEXT(a_in_busy, clk, rst_n, in_valid && in_ready, !in_ready, "input taken back to back")

  // a result only appears from an item in flight
  `SEOF_ASSERT_SAME(a_out_src, clk, rst_n, $rose(out_valid), !$past(in_ready), "result without item in flight")

endmodule

bind sobel_edge_overlay_filter seof_chk u_seof_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_payload ({out_ch.out_red, out_ch.out_green, out_ch.out_blue,
                 out_ch.out_alpha, out_ch.frame_last})
);

`default_nettype wire
